// ----- rtl/core/hws_pkg.sv -----
package hws_pkg;

    typedef logic [5:0] hws_state_t;

    // result of examining one item
    typedef struct packed {
        hws_state_t state;
        logic       keep;
    } hws_step_t;

    localparam hws_state_t S_TEXT        = 6'd0;
    localparam hws_state_t S_TEXT_WS     = 6'd1;
    localparam hws_state_t S_TAG         = 6'd2;
    localparam hws_state_t S_TAG_NAME    = 6'd3;
    localparam hws_state_t S_TAG_WS      = 6'd4;
    localparam hws_state_t S_ATTR_NAME   = 6'd5;
    localparam hws_state_t S_ATTR_EQ     = 6'd6;
    localparam hws_state_t S_ATTR_VAL    = 6'd7;
    localparam hws_state_t S_ATTR_DQ     = 6'd8;
    localparam hws_state_t S_ATTR_SQ     = 6'd9;
    localparam hws_state_t S_END_TAG     = 6'd10;
    localparam hws_state_t S_END_NAME    = 6'd11;
    localparam hws_state_t S_COMMENT     = 6'd12;
    localparam hws_state_t S_COMMENT_D   = 6'd13;
    localparam hws_state_t S_COMMENT_DD  = 6'd14;
    localparam hws_state_t S_BANG        = 6'd15;
    localparam hws_state_t S_BANG_DASH   = 6'd16;
    localparam hws_state_t S_BANG_STUFF  = 6'd17;
    localparam hws_state_t S_CD_OPEN0    = 6'd18;
    localparam hws_state_t S_CDATA       = 6'd24;
    localparam hws_state_t S_CDATA_B     = 6'd25;
    localparam hws_state_t S_CDATA_BB    = 6'd26;
    localparam hws_state_t S_PNAME0      = 6'd27;
    localparam hws_state_t S_PNAME_FULL  = 6'd29;
    localparam hws_state_t S_PRE_BODY    = 6'd30;
    localparam hws_state_t S_PRE_ANGLE   = 6'd31;
    localparam hws_state_t S_PRE_CL0     = 6'd32;
    localparam hws_state_t S_PRE_CL_FULL = 6'd35;
    localparam hws_state_t S_TNAME0      = 6'd36;
    localparam hws_state_t S_TNAME_FULL  = 6'd43;
    localparam hws_state_t S_TXA_BODY    = 6'd44;
    localparam hws_state_t S_TXA_ANGLE   = 6'd45;
    localparam hws_state_t S_TXA_CL0     = 6'd46;
    localparam hws_state_t S_TXA_CL_FULL = 6'd54;
    localparam hws_state_t S_ABORT       = 6'd55;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = to_lower(c);
        return (l >= 8'h61) && (l <= 8'h7A);
    endfunction

    // "CDATA["
    function automatic logic [7:0] cdata_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h43;
            3'd1:    return 8'h44;
            3'd2:    return 8'h41;
            3'd3:    return 8'h54;
            3'd4:    return 8'h41;
            3'd5:    return 8'h5B;
            default: return 8'h00;
        endcase
    endfunction

    // "pre"
    function automatic logic [7:0] pre_char(input logic [1:0] idx);
        case (idx)
            2'd0:    return 8'h70;
            2'd1:    return 8'h72;
            2'd2:    return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

    // "textarea"
    function automatic logic [7:0] txa_char(input logic [2:0] idx);
        case (idx)
            3'd0:    return 8'h74;
            3'd1:    return 8'h65;
            3'd2:    return 8'h78;
            3'd3:    return 8'h74;
            3'd4:    return 8'h61;
            3'd5:    return 8'h72;
            3'd6:    return 8'h65;
            3'd7:    return 8'h61;
            default: return 8'h00;
        endcase
    endfunction

endpackage

// ----- rtl/core/hws_next.sv -----
module hws_next (
    input  hws_pkg::hws_state_t state,
    input  logic [7:0]          in_byte,
    input  logic                doc_start,
    input  logic                enable,
    output hws_pkg::hws_step_t  step
);
    import hws_pkg::*;

    hws_state_t base;
    hws_state_t s;
    hws_state_t off_cd;
    hws_state_t off_pn;
    hws_state_t off_tn;
    hws_state_t off_pc;
    hws_state_t off_tc;
    logic [7:0] c;
    logic [7:0] lc;
    logic       keep;

    // tag name still a prefix of a keyword
    function automatic hws_state_t name_prefix(input logic [7:0] ch, input logic [7:0] expect_ch,
                                              input hws_state_t nxt);
        if (to_lower(ch) == expect_ch)
        begin
            return nxt;
        end
        if (ch == CH_SP)
        begin
            return S_TAG_WS;
        end
        if (ch == CH_GT)
        begin
            return S_TEXT;
        end
        return S_TAG_NAME;
    endfunction

    assign c      = in_byte;
    assign lc     = to_lower(in_byte);
    assign base   = doc_start ? S_TEXT : state;
    assign off_cd = base - S_CD_OPEN0;
    assign off_pn = base - S_PNAME0 + 6'd1;
    assign off_tn = base - S_TNAME0 + 6'd1;
    assign off_pc = base - S_PRE_CL0;
    assign off_tc = base - S_TXA_CL0;

    always_comb
    begin
        s    = base;
        keep = 1'b1;
        if (!enable)
        begin
            s = base;
        end
        else if (base >= S_CD_OPEN0 && base < S_CDATA)
        begin
            s = (c == cdata_char(off_cd[2:0])) ? base + 6'd1 : S_BANG_STUFF;
        end
        else if (base >= S_PNAME0 && base < S_PNAME_FULL)
        begin
            s = name_prefix(c, pre_char(off_pn[1:0]), base + 6'd1);
        end
        else if (base >= S_TNAME0 && base < S_TNAME_FULL)
        begin
            s = name_prefix(c, txa_char(off_tn[2:0]), base + 6'd1);
        end
        else if (base >= S_PRE_CL0 && base < S_PRE_CL_FULL)
        begin
            s = (lc == pre_char(off_pc[1:0])) ? base + 6'd1 : S_PRE_BODY;
        end
        else if (base >= S_TXA_CL0 && base < S_TXA_CL_FULL)
        begin
            s = (lc == txa_char(off_tc[2:0])) ? base + 6'd1 : S_TXA_BODY;
        end
        else
        begin
            case (base)
                S_TEXT:
                begin
                    if (c == CH_CR || c == CH_LF || c == CH_TAB)
                        keep = 1'b0;
                    else if (c == CH_LT)
                        s = S_TAG;
                    else if (c == CH_SP)
                        s = S_TEXT_WS;
                end
                S_TEXT_WS:
                begin
                    if (c == CH_CR || c == CH_LF || c == CH_TAB || c == CH_SP)
                        keep = 1'b0;
                    else
                        s = (c == CH_LT) ? S_TAG : S_TEXT;
                end
                S_TAG:
                begin
                    if (c == CH_BANG)
                        s = S_BANG;
                    else if (c == CH_SLASH)
                        s = S_END_TAG;
                    else if (lc == 8'h70)
                        s = S_PNAME0;
                    else if (lc == 8'h74)
                        s = S_TNAME0;
                    else if (c == CH_SP)
                        s = S_TAG;
                    else
                        s = is_letter(c) ? S_TAG_NAME : S_ABORT;
                end
                S_TAG_NAME, S_ATTR_VAL:
                begin
                    if (c == CH_GT)
                        s = S_TEXT;
                    else if (c == CH_SP)
                        s = S_TAG_WS;
                end
                S_TAG_WS:
                begin
                    if (c == CH_SP)
                        keep = 1'b0;
                    else
                        s = (c == CH_GT) ? S_TEXT : S_ATTR_NAME;
                end
                S_ATTR_NAME:
                begin
                    if (c == CH_EQ)
                        s = S_ATTR_EQ;
                    else if (c == CH_GT)
                        s = S_TEXT;
                    else if (c == CH_SP)
                        s = S_TAG_WS;
                end
                S_ATTR_EQ:
                begin
                    if (c == CH_DQ)
                        s = S_ATTR_DQ;
                    else if (c == CH_SQ)
                        s = S_ATTR_SQ;
                    else
                        s = S_ATTR_VAL;
                end
                S_ATTR_DQ:
                begin
                    if (c == CH_DQ)
                        s = S_ATTR_VAL;
                end
                S_ATTR_SQ:
                begin
                    if (c == CH_SQ)
                        s = S_ATTR_VAL;
                end
                S_END_TAG:
                begin
                    if (c == CH_SP)
                        keep = 1'b0;
                    else
                        s = S_END_NAME;
                end
                S_END_NAME, S_BANG_STUFF:
                begin
                    if (c == CH_GT)
                        s = S_TEXT;
                end
                S_COMMENT:
                begin
                    if (c == CH_DASH)
                        s = S_COMMENT_D;
                end
                S_COMMENT_D:
                begin
                    s = (c == CH_DASH) ? S_COMMENT_DD : S_COMMENT;
                end
                S_COMMENT_DD:
                begin
                    if (c == CH_GT)
                        s = S_TEXT;
                    else if (c != CH_DASH)
                        s = S_COMMENT;
                end
                S_BANG:
                begin
                    if (c == CH_DASH)
                        s = S_BANG_DASH;
                    else if (c == CH_LBR)
                        s = S_CD_OPEN0;
                    else
                        s = S_BANG_STUFF;
                end
                S_BANG_DASH:
                begin
                    s = (c == CH_DASH) ? S_COMMENT : S_BANG_STUFF;
                end
                S_CDATA:
                begin
                    if (c == CH_RBR)
                        s = S_CDATA_B;
                end
                S_CDATA_B:
                begin
                    s = (c == CH_RBR) ? S_CDATA_BB : S_CDATA;
                end
                S_CDATA_BB:
                begin
                    s = (c == CH_GT) ? S_TEXT : S_CDATA;
                end
                S_PNAME_FULL:
                begin
                    s = (c == CH_SP || c == CH_GT) ? S_PRE_BODY : S_TAG_NAME;
                end
                S_TNAME_FULL:
                begin
                    s = (c == CH_SP || c == CH_GT) ? S_TXA_BODY : S_TAG_NAME;
                end
                S_PRE_BODY:
                begin
                    if (c == CH_LT)
                        s = S_PRE_ANGLE;
                end
                S_PRE_ANGLE:
                begin
                    s = (c == CH_SLASH) ? S_PRE_CL0 : S_PRE_BODY;
                end
                S_PRE_CL_FULL:
                begin
                    s = (c == CH_GT) ? S_TEXT : S_PRE_BODY;
                end
                S_TXA_BODY:
                begin
                    if (c == CH_LT)
                        s = S_TXA_ANGLE;
                end
                S_TXA_ANGLE:
                begin
                    s = (c == CH_SLASH) ? S_TXA_CL0 : S_TXA_BODY;
                end
                S_TXA_CL_FULL:
                begin
                    s = (c == CH_GT) ? S_TEXT : S_TXA_BODY;
                end
                default:
                begin
                    // pass-through state and unused codes hold
                    s = base;
                end
            endcase
        end
    end

    assign step.state = s;
    assign step.keep  = keep;

endmodule

// ----- rtl/core/html_whitespace_stripper.sv -----
// an accepted item passes through the input register and then the result register to the output
// throughput: 1 item per cycle while the output is not stalled; the parser state register closes a feedback loop
// dropped items leave no result and do not occupy the result register
// reset clears the parser state to plain text, enable to 0 and both valid flags
module html_whitespace_stripper (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // in_byte [7:0]
    input  logic       s_axis_tuser,   // doc_start [0]
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // out_byte [7:0]
);
    import hws_pkg::*;

    logic       enable_reg;
    hws_state_t state_reg;
    hws_state_t state_next;
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_free;
    logic       fire;
    logic       s_accept;
    hws_step_t  step;

    hws_next u_next (
        .state     (state_reg),
        .in_byte   (in_byte_reg),
        .doc_start (in_start_reg),
        .enable    (enable_reg),
        .step      (step)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;

    always_comb
    begin
        state_next     = fire ? step.state : state_reg;
        in_valid_next  = s_accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = step.keep;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            state_reg     <= S_TEXT;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
            state_reg     <= state_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
        if (fire && step.keep)
        begin
            out_byte_reg <= in_byte_reg;
        end
    end

    // unused state codes are never entered
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= S_ABORT)
        else $error("parser state out of range");

    // with stripping off every item yields a result
    a_disabled_pass: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !enable_reg |=> out_valid_reg)
        else $error("item lost while disabled");

    // only a new response leaves the pass-through state
    a_abort_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ABORT && !(in_valid_reg && in_start_reg) |=> state_reg == S_ABORT)
        else $error("pass-through state left without doc start");

    // a stalled result is not overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg && $stable(out_byte_reg))
        else $error("pending result overwritten");

endmodule
